[rtl/bth_pkg.sv]
package bth_pkg;

  typedef struct packed {
    logic        kind;
    logic [16:0] request_size;
    logic        user_heap;
    logic [5:0]  extra_flags;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic [31:0] payload_address;
    logic [2:0]  status;
  } rsp_t;

  localparam logic [2:0] StAllocated = 3'd0;
  localparam logic [2:0] StFreed     = 3'd1;
  localparam logic [2:0] StZeroSize  = 3'd2;
  localparam logic [2:0] StIgnored   = 3'd3;
  localparam logic [2:0] StNoMemory  = 3'd4;

  localparam logic [1:0] RegKernelBase = 2'd0;
  localparam logic [1:0] RegUserBase   = 2'd1;
  localparam logic [1:0] RegCoalesce   = 2'd2;

  localparam logic [31:0] FPresent  = 32'h0100_0000;
  localparam logic [31:0] FUser     = 32'h0200_0000;
  localparam logic [31:0] SizeMask  = 32'h00FF_FFFF;
  localparam logic [31:0] MinSplit  = 32'd16;

endpackage

[rtl/boundary_tag_heap_allocator.sv]
// Boundary-tag heap allocator for a kernel heap and a user heap.
// Input channel (in_valid_i/in_ready_o, in_data_i) carries allocate or free
// transactions; output channel (out_valid_o/out_ready_i, out_data_o) returns
// one result per transaction: payload address and status.
// One transaction is worked at a time. The tag RAM has one write port and
// one registered read port. An allocate reads the tag of each block walked,
// then makes up to 4 writes and posts the result; a free reads its header,
// may merge with free right and left neighbours, and posts the result. The
// block chain walk makes an allocate take longer as the number of blocks
// in the heap grows.
// The user writes registers over the APB port only while the block is idle;
// it is not enforced. 0 kernel heap base, 1 user heap base, 2 coalesce limit.
// Reset clears both heap tops and loads the register defaults; the tag
// RAM is not cleared, since only words below a heap top are ever read.
// A stalled receiver holds the result in the output register; the next
// transaction is taken once the result register is free.
module boundary_tag_heap_allocator #(
  parameter int unsigned HEAP_BYTES = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bth_pkg::req_t      in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bth_pkg::rsp_t      out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import bth_pkg::*;

  localparam int unsigned OW = $clog2(HEAP_BYTES) + 1; // offset width, holds HEAP_BYTES
  localparam int unsigned WW = $clog2(HEAP_BYTES) - 2; // word index width
  localparam int unsigned AW = WW + 1;
  localparam logic [33:0] HeapLim = 34'(HEAP_BYTES);

  typedef enum logic [4:0] {
    S_IDLE, S_ARD, S_AWAIT, S_AEVAL, S_SPL1, S_SPL2, S_SPL3, S_AHDR, S_AEXT,
    S_FRD, S_FWAIT, S_FEVAL, S_RRD, S_RWAIT, S_REVAL, S_HWR, S_LFRD, S_LFWAIT,
    S_LHRD, S_LHWAIT, S_LEVAL, S_LFTR, S_OUT
  } state_e;

  state_e      state_q;
  logic [31:0] kbase_q, ubase_q;
  logic [16:0] climit_q;
  logic [OW-1:0] ktop_q, utop_q;
  logic        h_q;
  logic [31:0] a_q, c_q, sz_q, hd_q, flags_q, ftr_q, l_q, lh_q;
  logic [31:0] top_q;
  logic [31:0] res_addr_q;
  logic [2:0]  res_st_q;
  logic        out_valid_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  bth_tag_ram #(.AW(AW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [AW-1:0] widx(logic h, logic [31:0] off);
    return {h, off[WW+1:2]};
  endfunction

  logic [31:0] keff, p_k, p_u, ubase_eff;
  assign keff = (kbase_q + 32'hFFF) & 32'hFFFF_F000;
  assign ubase_eff = ubase_q;
  assign p_k = in_data_i.block_address - keff;
  assign p_u = in_data_i.block_address - ubase_eff;
  logic [31:0] cur_base;
  assign cur_base = h_q ? ubase_q : keff;

  // APB
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      RegKernelBase: prdata = kbase_q;
      RegUserBase:   prdata = ubase_q;
      RegCoalesce:   prdata = {15'd0, climit_q};
      default:       prdata = '0;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = '{payload_address: res_addr_q, status: res_st_q};

  // tag RAM access, decoded from the state
  logic [33:0] rend;   // end of right neighbor: ftr + 12 + rsz
  logic [31:0] rsz, lsz;
  logic        r_merge;
  assign rsz  = rdata & SizeMask;
  assign lsz  = lh_q & SizeMask;
  assign rend = {2'b0, ftr_q} + 34'd12 + {2'b0, rsz};
  // right neighbor is free, small enough and inside the heap
  assign r_merge = !rdata[24] && rsz <= {15'd0, climit_q} && rend <= {2'b0, top_q};

  always_comb begin
    we = 1'b0; waddr = widx(h_q, c_q); wdata = '0; raddr = widx(h_q, c_q);
    case (state_q)
      S_SPL1: begin we = 1'b1; waddr = widx(h_q, c_q + 32'd4 + a_q); wdata = c_q; end
      S_SPL2: begin
        we = 1'b1; waddr = widx(h_q, c_q + 32'd8 + a_q);
        wdata = (sz_q - a_q - 32'd8) & SizeMask;
      end
      S_SPL3: begin
        we = 1'b1; waddr = widx(h_q, c_q + 32'd4 + sz_q); wdata = c_q + 32'd8 + a_q;
      end
      S_AHDR: begin we = 1'b1; wdata = flags_q | sz_q; end
      S_AEXT: begin we = 1'b1; waddr = widx(h_q, c_q + 32'd4 + a_q); wdata = c_q; end
      S_RRD, S_RWAIT: raddr = widx(h_q, ftr_q + 32'd4);
      S_REVAL: begin
        if (r_merge) begin
          we = 1'b1; waddr = widx(h_q, ftr_q + 32'd8 + rsz); wdata = c_q;
        end
      end
      S_HWR:  begin we = 1'b1; wdata = (hd_q & ~SizeMask) | (sz_q & SizeMask); end
      S_LFRD: raddr = widx(h_q, c_q - 32'd4);
      S_LHRD: raddr = widx(h_q, l_q);
      S_LEVAL: begin
        we = 1'b1; waddr = widx(h_q, l_q);
        wdata = (lh_q & ~SizeMask) | ((lsz + 32'd8 + sz_q) & SizeMask);
      end
      S_LFTR: begin we = 1'b1; waddr = widx(h_q, ftr_q); wdata = l_q; end
      default: ;
    endcase
  end

  logic [33:0] ext_end;
  assign ext_end = {2'b0, top_q} + 34'd8 + {2'b0, a_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kbase_q <= 32'd1048576; ubase_q <= 32'h1000_0000; climit_q <= 17'd65536;
      ktop_q <= '0; utop_q <= '0; out_valid_q <= 1'b0;
      h_q <= 1'b0; a_q <= '0; c_q <= '0; sz_q <= '0; hd_q <= '0; flags_q <= '0;
      ftr_q <= '0; l_q <= '0; lh_q <= '0; top_q <= '0;
      res_addr_q <= '0; res_st_q <= StAllocated;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          RegKernelBase: kbase_q <= pwdata;
          RegUserBase:   ubase_q <= pwdata;
          RegCoalesce:   climit_q <= pwdata[16:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid_i && in_ready_o) begin
          res_addr_q <= '0; c_q <= '0;
          a_q <= ({15'd0, in_data_i.request_size} + 32'd7) & ~32'd7;
          flags_q <= FPresent | (in_data_i.user_heap ? FUser : 32'd0)
                     | {in_data_i.extra_flags, 26'd0};
          if (!in_data_i.kind) begin
            h_q <= in_data_i.user_heap;
            top_q <= 32'(in_data_i.user_heap ? utop_q : ktop_q);
            if (in_data_i.request_size == '0) begin
              res_st_q <= StZeroSize; state_q <= S_OUT;
            end else state_q <= S_ARD;
          end else begin
            res_st_q <= StIgnored;
            if (in_data_i.block_address == '0) state_q <= S_OUT;
            else if (p_k >= 32'd4 && p_k < 32'(HEAP_BYTES)) begin
              h_q <= 1'b0; c_q <= p_k - 32'd4; top_q <= 32'(ktop_q);
              state_q <= (p_k[1:0] != 2'd0 || (p_k - 32'd4) >= 32'(ktop_q)) ? S_OUT : S_FRD;
            end else if (p_u >= 32'd4 && p_u < 32'(HEAP_BYTES)) begin
              h_q <= 1'b1; c_q <= p_u - 32'd4; top_q <= 32'(utop_q);
              state_q <= (p_u[1:0] != 2'd0 || (p_u - 32'd4) >= 32'(utop_q)) ? S_OUT : S_FRD;
            end else state_q <= S_OUT;
          end
        end
        // allocate walk
        S_ARD: begin
          if (c_q < top_q) state_q <= S_AWAIT;
          else if (ext_end > HeapLim) begin
            res_st_q <= StNoMemory; state_q <= S_OUT;
          end else begin
            c_q <= top_q; sz_q <= a_q; state_q <= S_AHDR;
          end
        end
        S_AWAIT: state_q <= S_AEVAL;
        S_AEVAL: begin
          sz_q <= rdata & SizeMask;
          if (!rdata[24] && (rdata & SizeMask) >= a_q) begin
            state_q <= ((rdata & SizeMask) - a_q >= MinSplit) ? S_SPL1 : S_AHDR;
          end else begin
            c_q <= c_q + 32'd8 + (rdata & SizeMask); state_q <= S_ARD;
          end
        end
        S_SPL1: state_q <= S_SPL2;
        S_SPL2: state_q <= S_SPL3;
        S_SPL3: begin sz_q <= a_q; state_q <= S_AHDR; end
        S_AHDR: begin
          res_st_q <= StAllocated; res_addr_q <= cur_base + c_q + 32'd4;
          if (c_q == top_q && ext_end <= HeapLim && sz_q == a_q && top_q == c_q)
            state_q <= S_AEXT;
          else state_q <= S_OUT;
        end
        S_AEXT: begin
          if (h_q) utop_q <= OW'(ext_end); else ktop_q <= OW'(ext_end);
          state_q <= S_OUT;
        end
        // free
        S_FRD: state_q <= S_FWAIT;
        S_FWAIT: state_q <= S_FEVAL;
        S_FEVAL: begin
          hd_q <= rdata & ~FPresent; sz_q <= rdata & SizeMask;
          ftr_q <= c_q + 32'd4 + (rdata & SizeMask);
          if (!rdata[24] || ({2'b0, c_q} + 34'd8 + {2'b0, rdata & SizeMask}) > {2'b0, top_q})
            state_q <= S_OUT;
          else begin
            res_st_q <= StFreed;
            state_q <= (c_q + 32'd8 + (rdata & SizeMask) < top_q) ? S_RRD : S_HWR;
          end
        end
        S_RRD: state_q <= S_RWAIT;
        S_RWAIT: state_q <= S_REVAL;
        S_REVAL: begin
          if (r_merge) begin
            sz_q <= sz_q + 32'd8 + rsz; ftr_q <= ftr_q + 32'd8 + rsz;
          end
          state_q <= S_HWR;
        end
        S_HWR: state_q <= (c_q != '0) ? S_LFRD : S_OUT;
        S_LFRD: state_q <= S_LFWAIT;
        S_LFWAIT: begin
          l_q <= rdata;
          state_q <= (rdata < c_q && rdata[1:0] == 2'd0) ? S_LHRD : S_OUT;
        end
        S_LHRD: state_q <= S_LHWAIT;
        S_LHWAIT: begin
          lh_q <= rdata;
          state_q <= (!rdata[24] && rsz <= {15'd0, climit_q}) ? S_LEVAL : S_OUT;
        end
        S_LEVAL: state_q <= S_LFTR;
        S_LFTR: state_q <= S_OUT;
        S_OUT: begin out_valid_q <= 1'b1; state_q <= S_IDLE; end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> out_valid_q) else $error("result lost");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, ktop_q} <= (OW+1)'(HEAP_BYTES)) && ({1'b0, utop_q} <= (OW+1)'(HEAP_BYTES)))
    else $error("heap top past end");
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_st_q != StAllocated |-> res_addr_q == '0)
    else $error("address on non-allocate");
`endif
endmodule

[rtl/bth_tag_ram.sv]
module bth_tag_ram #(
  parameter int unsigned AW = 15
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);
  logic [31:0] mem [2**AW];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
